>>> rtl/pci_device_search_walker_unit_macros.svh
// assertion macros used by the checker file
`ifndef PCI_DEVICE_SEARCH_WALKER_UNIT_MACROS_SVH
`define PCI_DEVICE_SEARCH_WALKER_UNIT_MACROS_SVH

// same-cycle implication
`define PDSW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pdsw_pkg.sv
// ----------------------------------------------------------------------------
// pdsw_pkg
// Shared types, codes and helpers of the configuration space search walker.
// ----------------------------------------------------------------------------
package pdsw_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_VENDOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DEVICE = 1'b1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    localparam logic [1:0] KIND_REQ       = 2'd0;
    localparam logic [1:0] KIND_BAR       = 2'd1;
    localparam logic [1:0] KIND_FOUND     = 2'd2;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd3;

    localparam logic [7:0]  OFF_ID      = 8'h00;
    localparam logic [7:0]  OFF_CLASS   = 8'h08;
    localparam logic [7:0]  OFF_HDR     = 8'h0C;
    localparam logic [7:0]  OFF_BAR0    = 8'h10;
    localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
    localparam int          BAR_COUNT   = 6;

    localparam int OUT_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] config_address;
        logic [31:0] bar_value;
        logic [2:0]  bar_num;
        logic [7:0]  bus_number;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [7:0]  base_class;
        logic [7:0]  subclass_code;
        logic [7:0]  programming_interface;
    } t_result;

    function automatic logic [31:0] cfg_addr(input logic [7:0] bus, input logic [4:0] slot,
                                             input logic [2:0] fn, input logic [7:0] off);
        return {1'b1, 7'd0, bus, slot, fn, off & 8'hFC};
    endfunction

endpackage

>>> rtl/pdsw_in_if.sv
// ----------------------------------------------------------------------------
// pdsw_in_if
// Input channel: search start or returned configuration dword.
// ----------------------------------------------------------------------------
interface pdsw_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] read_data;

    modport source (output valid, output action, output read_data, input ready);
    modport sink   (input valid, input action, input read_data, output ready);
endinterface

>>> rtl/pdsw_out_if.sv
// ----------------------------------------------------------------------------
// pdsw_out_if
// Output channel: read requests, BAR reports and search outcome.
// ----------------------------------------------------------------------------
interface pdsw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] config_address;
    logic [31:0] bar_value;
    logic [2:0]  bar_num;
    logic [7:0]  bus_number;
    logic [4:0]  device_number;
    logic [2:0]  function_number;
    logic [7:0]  base_class;
    logic [7:0]  subclass_code;
    logic [7:0]  programming_interface;

    modport source (output valid, output kind, output config_address, output bar_value,
                    output bar_num, output bus_number, output device_number,
                    output function_number, output base_class, output subclass_code,
                    output programming_interface, input ready);
    modport sink   (input valid, input kind, input config_address, input bar_value,
                    input bar_num, input bus_number, input device_number,
                    input function_number, input base_class, input subclass_code,
                    input programming_interface, output ready);
endinterface

>>> rtl/pdsw_out_fifo.sv
// ----------------------------------------------------------------------------
// pdsw_out_fifo
// Small result queue taking up to two beats per cycle, giving one per cycle while popped.
// ----------------------------------------------------------------------------
module pdsw_out_fifo #(
    parameter int DEPTH = pdsw_pkg::OUT_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  pdsw_pkg::t_result i_res0,
    input  pdsw_pkg::t_result i_res1,
    output logic              o_room,
    output logic              o_valid,
    output pdsw_pkg::t_result o_data,
    input  logic              i_pop
);
    import pdsw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    assign wr_ptr_1 = ptr_inc(r_wr_ptr);
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign do_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push_cnt == 2'd1) begin
            n_wr_ptr = wr_ptr_1;
        end else if (i_push_cnt == 2'd2) begin
            n_wr_ptr = ptr_inc(wr_ptr_1);
        end
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = CNT_W'(r_count + CNT_W'(i_push_cnt) - CNT_W'(do_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_res1;
        end
    end

endmodule

>>> rtl/pci_device_search_walker_unit.sv
// Walks configuration space bus by bus, slot by slot and function by function for a function
// whose vendor and device identifiers match the two target registers, emitting mechanism-1 read
// addresses and consuming the returned dwords. Every input beat is decided combinationally by
// the phase register and small compare/address-pack logic, so one beat per cycle is accepted
// whenever the output queue has room for two beats; its results appear at the output from the
// next cycle on. A start or a returned identifier, header or class dword yields one output beat,
// a returned BAR dword yields two (the report plus the next request or the found beat), so during
// the BAR phase the single output port sets the pace of the input.
// ----------------------------------------------------------------------------
// pci_device_search_walker_unit
// Configuration space search walker: phase/location registers and decision logic.
// ----------------------------------------------------------------------------
module pci_device_search_walker_unit #(
    parameter int OUT_DEPTH = pdsw_pkg::OUT_FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pdsw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdsw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pdsw_in_if.sink                           i_in,
    pdsw_out_if.source                        o_out
);
    import pdsw_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ID    = 5'b00010,
        PH_HDR   = 5'b00100,
        PH_CLASS = 5'b01000,
        PH_BAR   = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_bus, n_bus;
    logic [4:0]  r_slot, n_slot;
    logic [2:0]  r_fn, n_fn;
    logic [2:0]  r_bar, n_bar;
    logic [23:0] r_class, n_class;
    logic [15:0] r_target_vendor;
    logic [15:0] r_target_device;

    logic        accept;
    logic        room;
    logic [1:0]  push_cnt;
    t_result     res0, res1, fifo_data;

    logic [7:0]  ns_bus;
    logic [4:0]  ns_slot;
    logic        ns_more;
    logic [7:0]  nf_bus;
    logic [4:0]  nf_slot;
    logic [2:0]  nf_fn;
    logic        nf_more;
    logic        do_probe;
    logic        probe_nf;
    logic [2:0]  bar_next;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = room;
    assign bar_next = 3'(r_bar + 3'd1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_vendor <= '0;
            r_target_device <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_VENDOR: r_target_vendor <= i_cfg_data;
                REG_TARGET_DEVICE: r_target_device <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next slot and next function candidates
    always_comb begin
        ns_more = 1'b1;
        ns_slot = 5'(r_slot + 5'd1);
        ns_bus  = r_bus;
        if (r_slot == 5'd31) begin
            ns_bus = 8'(r_bus + 8'd1);
            if (r_bus == 8'd255) begin
                ns_more = 1'b0;
            end
        end
        if (r_fn != 3'd7) begin
            nf_bus  = r_bus;
            nf_slot = r_slot;
            nf_fn   = 3'(r_fn + 3'd1);
            nf_more = 1'b1;
        end else begin
            nf_bus  = ns_bus;
            nf_slot = ns_slot;
            nf_fn   = 3'd0;
            nf_more = ns_more;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_bus    = r_bus;
        n_slot   = r_slot;
        n_fn     = r_fn;
        n_bar    = r_bar;
        n_class  = r_class;
        res0     = '0;
        res1     = '0;
        push_cnt = 2'd0;
        do_probe = 1'b0;
        probe_nf = 1'b0;
        if (accept) begin
            if (i_in.action == ACT_START) begin
                n_bus   = '0;
                n_slot  = '0;
                n_fn    = '0;
                n_bar   = '0;
                n_class = '0;
                n_phase = PH_ID;
                res0.kind           = KIND_REQ;
                res0.config_address = cfg_addr(8'd0, 5'd0, 3'd0, OFF_ID);
                push_cnt = 2'd1;
            end else begin
                unique case (r_phase)
                    PH_ID: begin
                        if (i_in.read_data[15:0] == VENDOR_NONE) begin
                            do_probe = 1'b1;
                            probe_nf = (r_fn != 3'd0);
                        end else if (i_in.read_data[15:0] == r_target_vendor &&
                                     i_in.read_data[31:16] == r_target_device) begin
                            n_phase = PH_CLASS;
                            res0.kind           = KIND_REQ;
                            res0.config_address = cfg_addr(r_bus, r_slot, r_fn, OFF_CLASS);
                            push_cnt = 2'd1;
                        end else if (r_fn == 3'd0) begin
                            n_phase = PH_HDR;
                            res0.kind           = KIND_REQ;
                            res0.config_address = cfg_addr(r_bus, r_slot, r_fn, OFF_HDR);
                            push_cnt = 2'd1;
                        end else begin
                            do_probe = 1'b1;
                            probe_nf = 1'b1;
                        end
                    end
                    PH_HDR: begin
                        do_probe = 1'b1;
                        probe_nf = i_in.read_data[23];
                    end
                    PH_CLASS: begin
                        n_class = i_in.read_data[31:8];
                        n_bar   = '0;
                        n_phase = PH_BAR;
                        res0.kind           = KIND_REQ;
                        res0.config_address = cfg_addr(r_bus, r_slot, r_fn, OFF_BAR0);
                        push_cnt = 2'd1;
                    end
                    PH_BAR: begin
                        res0.kind                  = KIND_BAR;
                        res0.bar_value             = i_in.read_data;
                        res0.bar_num               = r_bar;
                        res0.bus_number            = r_bus;
                        res0.device_number         = r_slot;
                        res0.function_number       = r_fn;
                        res0.base_class            = r_class[23:16];
                        res0.subclass_code         = r_class[15:8];
                        res0.programming_interface = r_class[7:0];
                        push_cnt = 2'd2;
                        if (r_bar == 3'(BAR_COUNT - 1)) begin
                            n_phase = PH_IDLE;
                            n_bar   = '0;
                            res1    = res0;
                            res1.kind      = KIND_FOUND;
                            res1.bar_value = '0;
                            res1.bar_num   = '0;
                        end else begin
                            n_bar = bar_next;
                            res1.kind           = KIND_REQ;
                            res1.config_address = cfg_addr(r_bus, r_slot, r_fn,
                                                           8'(OFF_BAR0 + {3'd0, bar_next, 2'b00}));
                        end
                    end
                    PH_IDLE: ;
                    default: ;
                endcase
            end
        end
        // move on, then probe the next identifier or finish
        if (do_probe) begin
            push_cnt = 2'd1;
            if (probe_nf) begin
                n_bus  = nf_more ? nf_bus : 8'd0;
                n_slot = nf_slot;
                n_fn   = nf_fn;
            end else begin
                n_bus  = ns_more ? ns_bus : 8'd0;
                n_slot = ns_slot;
                n_fn   = 3'd0;
            end
            if (probe_nf ? nf_more : ns_more) begin
                n_phase = PH_ID;
                res0.kind           = KIND_REQ;
                res0.config_address = cfg_addr(n_bus, n_slot, n_fn, OFF_ID);
            end else begin
                n_phase   = PH_IDLE;
                res0.kind = KIND_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bus   <= '0;
            r_slot  <= '0;
            r_fn    <= '0;
            r_bar   <= '0;
            r_class <= '0;
        end else begin
            r_phase <= n_phase;
            r_bus   <= n_bus;
            r_slot  <= n_slot;
            r_fn    <= n_fn;
            r_bar   <= n_bar;
            r_class <= n_class;
        end
    end

    pdsw_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_valid    (o_out.valid),
        .o_data     (fifo_data),
        .i_pop      (o_out.ready)
    );

    assign o_out.kind                  = fifo_data.kind;
    assign o_out.config_address        = fifo_data.config_address;
    assign o_out.bar_value             = fifo_data.bar_value;
    assign o_out.bar_num               = fifo_data.bar_num;
    assign o_out.bus_number            = fifo_data.bus_number;
    assign o_out.device_number         = fifo_data.device_number;
    assign o_out.function_number       = fifo_data.function_number;
    assign o_out.base_class            = fifo_data.base_class;
    assign o_out.subclass_code         = fifo_data.subclass_code;
    assign o_out.programming_interface = fifo_data.programming_interface;

endmodule

>>> rtl/pdsw_checker.sv
// ----------------------------------------------------------------------------
// pdsw_checker
// Port-level checks of the search walker output beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "pci_device_search_walker_unit_macros.svh"

module pdsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [31:0] i_out_config_address,
    input logic [31:0] i_out_bar_value,
    input logic [2:0]  i_out_bar_num,
    input logic [7:0]  i_out_bus_number,
    input logic [4:0]  i_out_device_number,
    input logic [2:0]  i_out_function_number
);
    import pdsw_pkg::*;

    `PDSW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_config_address) && $stable(i_out_bar_value), "stalled output beat changed")
    `PDSW_ASSERT_IMPLY(a_req_form, i_clk, i_rst_n, i_out_valid && i_out_kind == KIND_REQ, i_out_config_address[31] && i_out_config_address[30:24] == 7'd0 && i_out_config_address[1:0] == 2'd0 && i_out_bar_value == 32'd0 && i_out_bus_number == 8'd0 && i_out_device_number == 5'd0 && i_out_function_number == 3'd0, "malformed read request beat")
    `PDSW_ASSERT_IMPLY(a_bar_form, i_clk, i_rst_n, i_out_valid && i_out_kind == KIND_BAR, i_out_bar_num <= 3'(BAR_COUNT - 1) && i_out_config_address == 32'd0, "malformed BAR report beat")
    `PDSW_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !i_out_valid, "output beat right after reset")

endmodule

bind pci_device_search_walker_unit pdsw_checker u_pdsw_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_kind            (o_out.kind),
    .i_out_config_address  (o_out.config_address),
    .i_out_bar_value       (o_out.bar_value),
    .i_out_bar_num         (o_out.bar_num),
    .i_out_bus_number      (o_out.bus_number),
    .i_out_device_number   (o_out.device_number),
    .i_out_function_number (o_out.function_number)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the configuration space search walker. A behavioural model of
// the walk runs alongside the block: every beat taken on the input channel is
// applied to the model, and the beats it predicts are matched in order against
// the output channel. The stimulus plays the part of configuration space,
// answering reads with data, shaped to a chosen outcome in the ID phase, under
// several target settings and with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import pdsw_pkg::*;

    typedef enum logic [2:0] {
        WALK_IDLE,
        WALK_ID,
        WALK_HDR,
        WALK_CLASS,
        WALK_BAR
    } t_walk_phase;

    typedef enum int {
        ID_ABSENT,
        ID_MATCH,
        ID_OTHER
    } t_id_sel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pdsw_in_if  in_ch ();
    pdsw_out_if out_ch ();

    pci_device_search_walker_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // walk model state
    t_walk_phase walk_phase;
    logic [7:0]  cur_bus;
    logic [4:0]  cur_slot;
    logic [2:0]  cur_fn;
    logic [2:0]  bar_cnt;
    logic [23:0] class_word;
    logic [15:0] tgt_vendor;
    logic [15:0] tgt_device;

    t_result     awaited_beats[$];
    int          error_count;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    function automatic t_result request_beat(logic [7:0] off);
        t_result b;
        b = '0;
        b.kind = KIND_REQ;
        b.config_address = {1'b1, 7'd0, cur_bus, cur_slot, cur_fn, off & 8'hFC};
        return b;
    endfunction

    function automatic t_result located_beat(logic [1:0] k, logic [31:0] bar,
                                             logic [2:0] idx);
        t_result b;
        b = '0;
        b.kind = k;
        b.bar_value = bar;
        b.bar_num = idx;
        b.bus_number = cur_bus;
        b.device_number = cur_slot;
        b.function_number = cur_fn;
        b.base_class = class_word[23:16];
        b.subclass_code = class_word[15:8];
        b.programming_interface = class_word[7:0];
        return b;
    endfunction

    // false once the walk has gone past the last bus
    function automatic bit step_slot();
        cur_fn = 3'd0;
        if (cur_slot != 5'd31) begin
            cur_slot++;
            return 1'b1;
        end
        cur_slot = 5'd0;
        if (cur_bus != 8'd255) begin
            cur_bus++;
            return 1'b1;
        end
        cur_bus = 8'd0;
        return 1'b0;
    endfunction

    function automatic bit step_function();
        if (cur_fn != 3'd7) begin
            cur_fn++;
            return 1'b1;
        end
        return step_slot();
    endfunction

    function automatic void probe_or_give_up(bit more);
        t_result b;
        if (more) begin
            walk_phase = WALK_ID;
            awaited_beats.push_back(request_beat(OFF_ID));
        end else begin
            walk_phase = WALK_IDLE;
            b = '0;
            b.kind = KIND_NOT_FOUND;
            awaited_beats.push_back(b);
        end
    endfunction

    function automatic void advance_walk(logic act, logic [31:0] data);
        if (act == ACT_START) begin
            cur_bus = '0;
            cur_slot = '0;
            cur_fn = '0;
            bar_cnt = '0;
            class_word = '0;
            walk_phase = WALK_ID;
            awaited_beats.push_back(request_beat(OFF_ID));
            return;
        end
        case (walk_phase)
            WALK_ID: begin
                if (data[15:0] == VENDOR_NONE) begin
                    probe_or_give_up(cur_fn == 3'd0 ? step_slot() : step_function());
                end else if (data[15:0] == tgt_vendor && data[31:16] == tgt_device) begin
                    walk_phase = WALK_CLASS;
                    awaited_beats.push_back(request_beat(OFF_CLASS));
                end else if (cur_fn == 3'd0) begin
                    walk_phase = WALK_HDR;
                    awaited_beats.push_back(request_beat(OFF_HDR));
                end else begin
                    probe_or_give_up(step_function());
                end
            end
            WALK_HDR: begin
                // multi-function flag of the header type byte
                probe_or_give_up(data[23] ? step_function() : step_slot());
            end
            WALK_CLASS: begin
                class_word = data[31:8];
                bar_cnt = '0;
                walk_phase = WALK_BAR;
                awaited_beats.push_back(request_beat(OFF_BAR0));
            end
            WALK_BAR: begin
                awaited_beats.push_back(located_beat(KIND_BAR, data, bar_cnt));
                if (int'(bar_cnt) + 1 >= BAR_COUNT) begin
                    walk_phase = WALK_IDLE;
                    awaited_beats.push_back(located_beat(KIND_FOUND, '0, '0));
                    bar_cnt = '0;
                end else begin
                    bar_cnt++;
                    awaited_beats.push_back(request_beat(OFF_BAR0 + {3'd0, bar_cnt, 2'b00}));
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [31:0] id_dword(t_id_sel sel);
        logic [15:0] ven;
        logic [15:0] dev;
        ven = 16'($urandom);
        dev = 16'($urandom);
        case (sel)
            ID_ABSENT: ven = VENDOR_NONE;
            ID_MATCH: begin
                ven = tgt_vendor;
                dev = tgt_device;
            end
            default: begin
                if (ven == VENDOR_NONE)
                    ven = 16'h0000;
                if (ven == tgt_vendor && dev == tgt_device)
                    dev = ~dev;
            end
        endcase
        return {dev, ven};
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{kind: out_ch.kind, config_address: out_ch.config_address,
                    bar_value: out_ch.bar_value, bar_num: out_ch.bar_num,
                    bus_number: out_ch.bus_number, device_number: out_ch.device_number,
                    function_number: out_ch.function_number,
                    base_class: out_ch.base_class, subclass_code: out_ch.subclass_code,
                    programming_interface: out_ch.programming_interface};
            if (awaited_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual kind %0d addr %h",
                         $time, got.kind, got.config_address);
                error_count++;
            end else begin
                want = awaited_beats.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("config_address", want.config_address, got.config_address);
                check_field("bar_value", want.bar_value, got.bar_value);
                check_field("bar_num", 32'(want.bar_num), 32'(got.bar_num));
                check_field("bus_number", 32'(want.bus_number), 32'(got.bus_number));
                check_field("device_number", 32'(want.device_number),
                            32'(got.device_number));
                check_field("function_number", 32'(want.function_number),
                            32'(got.function_number));
                check_field("base_class", 32'(want.base_class), 32'(got.base_class));
                check_field("subclass_code", 32'(want.subclass_code),
                            32'(got.subclass_code));
                check_field("programming_interface", 32'(want.programming_interface),
                            32'(got.programming_interface));
            end
        end
    end

    // receiver back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_item(logic act, logic [31:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.read_data <= data;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        advance_walk(act, data);
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_beats.size() != 0)
            @(posedge i_clk);
    endtask

    // a data beat while idle leaves nothing to wait for, so allow extra cycles
    task automatic wait_quiet();
        hold_until_drained();
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_targets(logic [15:0] vendor, logic [15:0] device);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_TARGET_VENDOR;
        i_cfg_data <= vendor;
        @(posedge i_clk);
        i_cfg_idx <= REG_TARGET_DEVICE;
        i_cfg_data <= device;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tgt_vendor = vendor;
        tgt_device = device;
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        set_targets(16'h5A3C, 16'hC3A5);
        send_item(ACT_DATA, 32'hFFFF_FFFF);            // ignored while idle
        send_item(ACT_START, 32'hFFFF_FFFF);
        send_item(ACT_DATA, 32'h0000_FFFF);            // empty slot at function 0
        send_item(ACT_DATA, 32'h0000_0000);
        send_item(ACT_DATA, 32'h0080_0000);            // multi-function header
        send_item(ACT_DATA, 32'hFFFF_FFFF);            // empty function 1
        send_item(ACT_DATA, 32'h1234_0001);
        send_item(ACT_DATA, 32'hC3A4_5A3C);            // vendor matches, device does not
        send_item(ACT_START, 32'h0000_0000);           // abandon running search
        send_item(ACT_DATA, 32'hFFFE_0000);
        send_item(ACT_DATA, 32'hFF7F_FFFF);            // single-function header
        send_item(ACT_DATA, 32'hC3A5_5A3C);
        send_item(ACT_DATA, 32'h0C03_3001);
        send_item(ACT_DATA, 32'h0000_0000);
        send_item(ACT_DATA, 32'hFFFF_FFFF);
        send_item(ACT_DATA, 32'hFEBF_0000);
        send_item(ACT_DATA, 32'h0000_E001);
        send_item(ACT_DATA, 32'h0000_000C);
        send_item(ACT_DATA, 32'h8000_0000);
        send_item(ACT_DATA, 32'h0000_0000);            // ignored after found
        wait_quiet();
    endtask

    task automatic test_random_search(int unsigned idle_pct, int unsigned stall_pct,
                                      int count, logic [15:0] vendor, logic [15:0] device);
        int          sent;
        int unsigned r;
        logic        act;
        logic [31:0] data;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        set_targets(vendor, device);
        sent = 0;
        while (sent < count) begin
            if (sent == count / 2 || $urandom_range(149) == 0)
                hold_until_drained();
            r = $urandom_range(99);
            act = ACT_DATA;
            data = $urandom;
            if (walk_phase == WALK_IDLE) begin
                if (r >= 5)
                    act = ACT_START;
            end else if (r < 2) begin
                act = ACT_START;
            end else if (r >= 4 && walk_phase == WALK_ID) begin
                r = $urandom_range(99);
                data = id_dword(r < 35 ? ID_ABSENT : (r < 60 ? ID_MATCH : ID_OTHER));
            end
            // data beats while idle do not count
            if (!(walk_phase == WALK_IDLE && act == ACT_DATA))
                sent++;
            send_item(act, data);
        end
        wait_quiet();
    endtask

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_START;
        in_ch.read_data = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        error_count = 0;
        walk_phase = WALK_IDLE;
        cur_bus = '0;
        cur_slot = '0;
        cur_fn = '0;
        bar_cnt = '0;
        class_word = '0;
        tgt_vendor = '0;
        tgt_device = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_search(0, 0, 385, 16'h0000, 16'h0000);
        test_random_search(87, 0, 385, 16'($urandom), 16'($urandom));
        test_random_search(0, 87, 385, 16'hFFFE, 16'hFFFF);
        test_random_search(35, 35, 385, 16'($urandom), 16'($urandom));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> pci_device_search_walker_unit.f
+incdir+rtl
rtl/pdsw_pkg.sv
rtl/pdsw_in_if.sv
rtl/pdsw_out_if.sv
rtl/pdsw_out_fifo.sv
rtl/pci_device_search_walker_unit.sv
rtl/pdsw_checker.sv
tb/tb_top.sv
